// ----- hw/rtl/ehc_pkg.sv -----
// ----------------------------------------------------------------------------
// Extended Hamming codec package
// Shared sizes, status and command codes, and block masks for the codec.
// ----------------------------------------------------------------------------
package ehc_pkg;

  // Block geometry. SIDE may range from 4 to 8; everything below follows it.
  localparam int SIDE   = 8;
  localparam int NBITS  = SIDE * SIDE;
  localparam int BLK_W  = 64;
  localparam int SYN_W  = 6;
  localparam int STAT_W = 2;

  // Command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_CLEAN  = 2'd0;
  localparam logic [STAT_W-1:0] ST_CORR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;

  // Bits of the 64-bit port that belong to the block.
  function automatic logic [BLK_W-1:0] calc_block_mask();
    logic [BLK_W-1:0] m;
    m = '0;
    for (int i = 0; i < NBITS; i++) begin
      m[i] = 1'b1;
    end
    return m;
  endfunction

  // Overall parity at position 0 and Hamming parity at each power of two.
  function automatic logic [BLK_W-1:0] calc_parity_mask();
    logic [BLK_W-1:0] m;
    m = '0;
    for (int i = 0; i < NBITS; i++) begin
      if ((i & (i - 1)) == 0) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam logic [BLK_W-1:0] BLOCK_MASK  = calc_block_mask();
  localparam logic [BLK_W-1:0] PARITY_MASK = calc_parity_mask();

  // Syndrome and overall parity of one block, passed from the syndrome generator to the correction logic.
  typedef struct packed {
    logic [SYN_W-1:0] syndrome;
    logic             parity;
  } ehc_syn_t;

endpackage

// ----- hw/rtl/ehc_syndrome.sv -----
// ----------------------------------------------------------------------------
// Syndrome generator
// Masks the block, then forms the index XOR and the overall parity of it.
// ----------------------------------------------------------------------------
module ehc_syndrome (
  input  logic                 cmd,
  input  logic [ehc_pkg::BLK_W-1:0] blk,
  output logic [ehc_pkg::BLK_W-1:0] blk_masked,
  output ehc_pkg::ehc_syn_t    syn
);
  import ehc_pkg::*;

  logic [SYN_W-1:0] syn_acc;

  // In encode mode the incoming parity positions are cleared first.
  assign blk_masked = (cmd == CMD_CHECK) ? (blk & BLOCK_MASK)
                                         : (blk & BLOCK_MASK & ~PARITY_MASK);

  always_comb begin
    syn_acc = '0;
    for (int i = 0; i < NBITS; i++) begin
      if (blk_masked[i]) begin
        syn_acc = syn_acc ^ SYN_W'(i);
      end
    end
  end

  assign syn.syndrome = syn_acc;
  assign syn.parity   = ^blk_masked;

endmodule

// ----- hw/rtl/ehc_correct.sv -----
// ----------------------------------------------------------------------------
// Parity insertion and single-error correction
// Builds the codeword in encode mode, or classifies and repairs in check mode.
// ----------------------------------------------------------------------------
module ehc_correct (
  input  logic                       cmd,
  input  logic [ehc_pkg::BLK_W-1:0]  blk_masked,
  input  ehc_pkg::ehc_syn_t          syn,
  output logic [ehc_pkg::BLK_W-1:0]  block_out,
  output logic [ehc_pkg::SYN_W-1:0]  syndrome,
  output logic [ehc_pkg::STAT_W-1:0] status
);
  import ehc_pkg::*;

  logic [BLK_W-1:0] enc_ham;
  logic [BLK_W-1:0] enc_word;
  logic [BLK_W-1:0] flip_bit;
  logic             syn_in_block;

  // Place each syndrome bit at its power-of-two position.
  always_comb begin
    enc_ham = '0;
    for (int k = 0; k < SYN_W; k++) begin
      if ((1 << k) < NBITS) begin
        enc_ham[1 << k] = syn.syndrome[k];
      end
    end
  end

  // Overall parity makes the whole codeword even.
  always_comb begin
    enc_word    = blk_masked | enc_ham;
    enc_word[0] = ^(blk_masked | enc_ham);
  end

  assign syn_in_block = ({1'b0, syn.syndrome} < (SYN_W + 1)'(NBITS));
  assign flip_bit     = BLK_W'(1) << syn.syndrome;

  always_comb begin
    block_out = blk_masked;
    syndrome  = '0;
    status    = ST_CLEAN;
    if (cmd == CMD_ENCODE) begin
      block_out = enc_word;
    end else begin
      syndrome = syn.syndrome;
      priority if (syn.parity && syn_in_block) begin
        block_out = (blk_masked ^ flip_bit) & BLOCK_MASK;
        status    = ST_CORR;
      end else if (syn.parity) begin
        status    = ST_DOUBLE;
      end else if (syn.syndrome != '0) begin
        status    = ST_DOUBLE;
      end else begin
        status    = ST_CLEAN;
      end
    end
  end

endmodule

// ----- hw/rtl/extended_hamming_block_codec_unit.sv -----
// ----------------------------------------------------------------------------
// Extended Hamming block codec unit
// SECDED encoder and checker for one SIDE by SIDE bit block per request.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while in_stall is low and returns one
// result per request from its result register. A request
// first lands in an input register; the syndrome XOR tree, the parity
// insertion and the single-bit repair then run in one combinational pass into
// the result register. Sustained throughput is one request per clock, set by
// that single pass; stalls on the result side hold the result register and,
// when the input register is also full, stall the input side. With cmd low
// the parity positions of the block are recomputed and the codeword returned
// with syndrome and status zero. With cmd high the block is checked: clean,
// single error corrected, or double error detected. Bits of block_in above
// SIDE*SIDE are ignored and those of block_out are zero.
module extended_hamming_block_codec_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [ehc_pkg::BLK_W-1:0]  in_block_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ehc_pkg::BLK_W-1:0]  out_block_out,
  output logic [ehc_pkg::SYN_W-1:0]  out_syndrome,
  output logic [ehc_pkg::STAT_W-1:0] out_status
);
  import ehc_pkg::*;

  // Input register stage.
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             s1_cmd_r;
  logic [BLK_W-1:0] s1_blk_r;

  // Result register stage.
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  logic [BLK_W-1:0]  s2_blk_r;
  logic [SYN_W-1:0]  s2_syn_r;
  logic [STAT_W-1:0] s2_stat_r;

  logic              s2_load;
  logic              in_take;

  logic [BLK_W-1:0]  blk_masked;
  ehc_syn_t          syn;
  logic [BLK_W-1:0]  res_blk;
  logic [SYN_W-1:0]  res_syn;
  logic [STAT_W-1:0] res_stat;

  // The result register can take a new value when it is empty or drained.
  assign s2_load  = !s2_valid_r || !out_stall;
  // The input register is free when empty or when it moves on this cycle.
  assign in_stall = s1_valid_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  assign s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_cmd;
      s1_blk_r <= in_block_in;
    end
  end

  ehc_syndrome u_syndrome (
    .cmd        (s1_cmd_r),
    .blk        (s1_blk_r),
    .blk_masked (blk_masked),
    .syn        (syn)
  );

  ehc_correct u_correct (
    .cmd        (s1_cmd_r),
    .blk_masked (blk_masked),
    .syn        (syn),
    .block_out  (res_blk),
    .syndrome   (res_syn),
    .status     (res_stat)
  );

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_blk_r  <= res_blk;
      s2_syn_r  <= res_syn;
      s2_stat_r <= res_stat;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_block_out = s2_blk_r;
  assign out_syndrome  = s2_syn_r;
  assign out_status    = s2_stat_r;

`ifndef SYNTHESIS
  // A request in the input register moves to the output when it is free.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_load) |=> out_valid)
    else $error("request lost between input and result registers");

  // A corrected block always carries even overall parity.
  a_corr_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CORR) |-> (^out_block_out == 1'b0))
    else $error("corrected block has odd parity");

  // A clean result never reports a nonzero syndrome.
  a_clean_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CLEAN) |-> (out_syndrome == '0))
    else $error("clean status with nonzero syndrome");

  // Input stalls only while the input register holds a waiting request.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled without a full pipeline");
`endif

endmodule

// ----- test/extended_hamming_block_codec_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Hamming block codec unit testbench
// Drives encode and check requests through the SECDED codec with random gaps
// on the request side and random stalls on the result side, predicts every
// result in the bench and compares the returned block, syndrome and status.
// ----------------------------------------------------------------------------
module extended_hamming_block_codec_unit_test;

  import ehc_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Random requests after the directed ones.
  localparam int RANDOM_REQS = 1950;

  // One request as the driver presents it, plus the idle cycles that follow it.
  typedef struct {
    logic            cmd;
    logic [BLK_W-1:0] block;
    int unsigned     gap;
  } codec_req_t;

  // One result as the unit should return it.
  typedef struct packed {
    logic [BLK_W-1:0]  block_out;
    logic [SYN_W-1:0]  syndrome;
    logic [STAT_W-1:0] status;
  } codec_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_ENCODE;
  logic [BLK_W-1:0]  in_block_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BLK_W-1:0]  out_block_out;
  logic [SYN_W-1:0]  out_syndrome;
  logic [STAT_W-1:0] out_status;

  codec_req_t    codec_reqs[$];
  codec_result_t predicted_words[$];

  // Handshake flags captured at the rising edge for the falling-edge drivers.
  logic req_taken = 1'b0;
  logic word_taken = 1'b0;

  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  bit          stall_calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          gap_calm = 1'b0;

  extended_hamming_block_codec_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_out (out_block_out),
    .out_syndrome  (out_syndrome),
    .out_status    (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench-side SECDED predictor. The syndrome is the XOR of the indices of all
  // set bits inside the block, and the overall parity is their count mod two.
  // Encoding clears the parity positions, writes the syndrome of the data into
  // the power-of-two positions and then evens out the overall parity at bit 0.
  // Checking repairs a single error at the syndrome index, where a syndrome of
  // zero with odd parity means the overall parity bit itself was hit.
  function automatic codec_result_t secded_predict(logic cmd, logic [BLK_W-1:0] word);
    codec_result_t    res;
    logic [BLK_W-1:0] blk;
    logic [SYN_W-1:0] syn;
    logic             par;
    blk = '0;
    syn = '0;
    par = 1'b0;
    for (int i = 0; i < NBITS; i++) begin
      blk[i] = word[i];
      if (cmd == CMD_ENCODE && (i & (i - 1)) == 0) begin
        blk[i] = 1'b0;
      end
    end
    for (int i = 0; i < NBITS; i++) begin
      if (blk[i]) begin
        syn ^= SYN_W'(i);
        par ^= 1'b1;
      end
    end
    res.syndrome = '0;
    res.status   = ST_CLEAN;
    if (cmd == CMD_ENCODE) begin
      for (int p = 1; p < NBITS; p = p << 1) begin
        if ((int'(syn) & p) != 0) begin
          blk[p] = 1'b1;
          par ^= 1'b1;
        end
      end
      blk[0] = par;
    end else begin
      res.syndrome = syn;
      if (par) begin
        // A syndrome past the block can only arise when the block size is not
        // a power of two; the error is then beyond repair.
        if (int'(syn) < NBITS) begin
          blk[syn] = ~blk[syn];
          res.status = ST_CORR;
        end else begin
          res.status = ST_DOUBLE;
        end
      end else if (syn != '0) begin
        res.status = ST_DOUBLE;
      end
    end
    res.block_out = blk;
    return res;
  endfunction

  function automatic logic [BLK_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Queue a request. Calm stretches switch on and off now and then so that
  // long back-to-back runs alternate with runs of random gaps.
  task automatic queue_request(logic cmd, logic [BLK_W-1:0] block);
    codec_req_t req;
    if ($urandom_range(0, 63) == 0) begin
      gap_calm = ~gap_calm;
    end
    req.cmd   = cmd;
    req.block = block;
    req.gap   = gap_calm ? 0 : $urandom_range(0, 11);
    codec_reqs.push_back(req);
  endtask

  // Request driver: changes inputs on the falling edge and holds a request
  // until the rising edge at which it was taken.
  always @(negedge clk) begin
    codec_req_t req;
    if (rst_n && (!in_valid || req_taken)) begin
      if (idle_left > 0) begin
        in_valid    <= 1'b0;
        in_cmd      <= 1'($urandom_range(0, 1));
        in_block_in <= random_word();
        idle_left   <= idle_left - 1;
      end else if (codec_reqs.size() > 0) begin
        req = codec_reqs.pop_front();
        in_valid    <= 1'b1;
        in_cmd      <= req.cmd;
        in_block_in <= req.block;
        idle_left   <= req.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: a fresh stall length is drawn after every taken result.
  always @(negedge clk) begin
    int unsigned n;
    if (word_taken) begin
      if ($urandom_range(0, 63) == 0) begin
        stall_calm = ~stall_calm;
      end
      n = stall_calm ? 0 : $urandom_range(0, 11);
      out_stall  <= (n > 0);
      stall_left <= (n > 0) ? n - 1 : 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks each taken result against the oldest prediction, then
  // predicts the request taken at this edge. A result never leaves in the same
  // cycle its request is taken, so checking first is safe.
  always @(posedge clk) begin
    codec_result_t want;
    req_taken  <= rst_n && in_valid && !in_stall;
    word_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_words.size() == 0) begin
          $error("result with no request outstanding: block_out %h", out_block_out);
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          if (out_block_out !== want.block_out) begin
            $error("block_out: expected %h, got %h", want.block_out, out_block_out);
            mismatches++;
          end
          if (out_syndrome !== want.syndrome) begin
            $error("syndrome: expected %0d, got %0d", want.syndrome, out_syndrome);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_words.push_back(secded_predict(in_cmd, in_block_in));
      end
    end
  end

  // Watchdog: the run is hung if no handshake happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    codec_result_t    enc_res;
    logic [BLK_W-1:0] cw;
    logic [BLK_W-1:0] word;
    int               pick;
    int               p1;
    int               p2;
    int               p3;

    // Directed requests: extreme patterns in both modes, a clean codeword,
    // single errors on the overall parity bit, a Hamming parity bit and data
    // bits, double errors with and without the overall parity bit, and a
    // triple error that aliases to a wrong repair.
    enc_res = secded_predict(CMD_ENCODE, random_word());
    cw = enc_res.block_out;
    queue_request(CMD_ENCODE, '0);
    queue_request(CMD_ENCODE, '1);
    queue_request(CMD_ENCODE, {(BLK_W/2){2'b10}});
    queue_request(CMD_ENCODE, {(BLK_W/2){2'b01}});
    queue_request(CMD_ENCODE, 64'h0000_0001_0001_0117);
    queue_request(CMD_CHECK, '0);
    queue_request(CMD_CHECK, '1);
    queue_request(CMD_CHECK, 64'h1);
    queue_request(CMD_CHECK, 64'h8000_0000_0000_0000);
    queue_request(CMD_CHECK, cw);
    queue_request(CMD_CHECK, cw ^ 64'h1);
    queue_request(CMD_CHECK, cw ^ (64'h1 << (NBITS - 1)));
    queue_request(CMD_CHECK, cw ^ (64'h1 << 32));
    queue_request(CMD_CHECK, cw ^ (64'h1 << 37));
    queue_request(CMD_CHECK, cw ^ (64'h1 << 3) ^ (64'h1 << 5));
    queue_request(CMD_CHECK, cw ^ 64'h1 ^ (64'h1 << 12));
    queue_request(CMD_CHECK, cw ^ (64'h1 << 1) ^ (64'h1 << 2) ^ (64'h1 << 40));
    queue_request(CMD_CHECK, {(BLK_W/2){2'b10}});
    queue_request(CMD_CHECK, random_word());

    // Random requests. Most checks start from a valid codeword so that the
    // clean, corrected and double-error paths are all well exercised; the
    // rest are encodes and raw noise.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      word = random_word();
      if (pick < 25) begin
        queue_request(CMD_ENCODE, word);
      end else if (pick < 95) begin
        enc_res = secded_predict(CMD_ENCODE, word);
        cw = enc_res.block_out;
        p1 = $urandom_range(0, NBITS - 1);
        p2 = (p1 + $urandom_range(1, NBITS - 1)) % NBITS;
        p3 = $urandom_range(0, NBITS - 1);
        if (pick >= 40) begin
          cw[p1] = ~cw[p1];
        end
        if (pick >= 70) begin
          cw[p2] = ~cw[p2];
        end
        if (pick >= 88 && p3 != p1 && p3 != p2) begin
          cw[p3] = ~cw[p3];
        end
        queue_request(CMD_CHECK, cw);
      end else begin
        queue_request(CMD_CHECK, word);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (codec_reqs.size() != 0 || in_valid || predicted_words.size() != 0) begin
      @(posedge clk);
    end
    // Keep the clock running so that any stray result still shows up.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
